### rtl/kwl_pkg.sv
// Package for the keyword token lexer: token codes, byte codes, the token
// record type and the symbol decode function. No dependencies.
`default_nettype none
package kwl_pkg;

    localparam int CNT_WIDTH_DEF = 16;
    localparam int FIELD_W       = 16;
    localparam int KIND_W        = 4;
    localparam int CHAR_W        = 8;
    localparam int TDATA_W       = 72;
    localparam int TOK_BITS      = KIND_W + 4 * FIELD_W;

    localparam logic [KIND_W-1:0] TOK_EOF     = 4'd0;
    localparam logic [KIND_W-1:0] TOK_LPAREN  = 4'd1;
    localparam logic [KIND_W-1:0] TOK_RPAREN  = 4'd2;
    localparam logic [KIND_W-1:0] TOK_LBRACE  = 4'd3;
    localparam logic [KIND_W-1:0] TOK_RBRACE  = 4'd4;
    localparam logic [KIND_W-1:0] TOK_SEMI    = 4'd5;
    localparam logic [KIND_W-1:0] TOK_ASSIGN  = 4'd6;
    localparam logic [KIND_W-1:0] TOK_PLUS    = 4'd7;
    localparam logic [KIND_W-1:0] TOK_MINUS   = 4'd8;
    localparam logic [KIND_W-1:0] TOK_SLASH   = 4'd9;
    localparam logic [KIND_W-1:0] TOK_STAR    = 4'd10;
    localparam logic [KIND_W-1:0] TOK_IF      = 4'd11;
    localparam logic [KIND_W-1:0] TOK_ELSE    = 4'd12;
    localparam logic [KIND_W-1:0] TOK_ELSEIF  = 4'd13;
    localparam logic [KIND_W-1:0] TOK_IDENT   = 4'd14;
    localparam logic [KIND_W-1:0] TOK_UNKNOWN = 4'd15;

    localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NL     = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;
    localparam logic [CHAR_W-1:0] CH_ASSIGN = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
    localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;
    localparam logic [CHAR_W-1:0] CH_UNDER  = 8'h5F;
    localparam logic [CHAR_W-1:0] CH_LOW_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOW_Z  = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_UP_A   = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_Z   = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_DIG_0  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_DIG_9  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_E      = 8'h65;
    localparam logic [CHAR_W-1:0] CH_F      = 8'h66;
    localparam logic [CHAR_W-1:0] CH_I      = 8'h69;
    localparam logic [CHAR_W-1:0] CH_L      = 8'h6C;
    localparam logic [CHAR_W-1:0] CH_S      = 8'h73;

    typedef struct packed {
        logic                  last;
        logic [FIELD_W-1:0]    column;
        logic [FIELD_W-1:0]    line;
        logic [FIELD_W-1:0]    length;
        logic [FIELD_W-1:0]    offset;
        logic [KIND_W-1:0]     kind;
    } tok_t;

    function automatic logic [KIND_W-1:0] single_kind(input logic [CHAR_W-1:0] c);
        logic [KIND_W-1:0] k;
        unique case (c)
            CH_NUL:    k = TOK_EOF;
            CH_LPAREN: k = TOK_LPAREN;
            CH_RPAREN: k = TOK_RPAREN;
            CH_LBRACE: k = TOK_LBRACE;
            CH_RBRACE: k = TOK_RBRACE;
            CH_SEMI:   k = TOK_SEMI;
            CH_ASSIGN: k = TOK_ASSIGN;
            CH_PLUS:   k = TOK_PLUS;
            CH_MINUS:  k = TOK_MINUS;
            CH_SLASH:  k = TOK_SLASH;
            CH_STAR:   k = TOK_STAR;
            default:   k = TOK_UNKNOWN;
        endcase
        return k;
    endfunction

endpackage
`default_nettype wire

### rtl/keyword_token_lexer_top.sv
// Top level of the keyword token lexer: byte input stream, token output stream.
// Instantiates kwl_core and kwl_tok_fifo; uses kwl_pkg.
//
//  Channel | Dir | tdata (low bit first)                            | tlast
//  s_      | in  | char_code[7:0]                                   | -
//  m_      | out | token_type, token_offset, token_length,          | last_of_run
//          |     | token_line, token_column, 4 zero bits            |
//
// One byte is taken per cycle while the token queue has room; a token is
// presented at m_ after its byte has passed the input register and the token
// queue. A non-whitespace byte that closes a word gives two transfers; the
// four-entry token queue absorbs them while m_ drains one per cycle of m_tready.
// The input stalls while that queue has fewer than two free entries.
// Reset is synchronous on aresetn low and clears all counters and the queue.
`default_nettype none
module keyword_token_lexer_top
    import kwl_pkg::*;
#(
    parameter int COUNTER_WIDTH = CNT_WIDTH_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [CHAR_W-1:0]  s_tdata,   // char_code
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [TDATA_W-1:0]      m_tdata,   // type, offset, length, line, column
    output logic                    m_tlast
);

    logic [1:0] push_n;
    logic       room;
    tok_t       tok0, tok1, head;

    kwl_core #(
        .COUNTER_WIDTH(COUNTER_WIDTH)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_char  (s_tdata),
        .room     (room),
        .push_n   (push_n),
        .tok0     (tok0),
        .tok1     (tok1)
    );

    kwl_tok_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_n    (push_n),
        .tok0      (tok0),
        .tok1      (tok1),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_tok   (head)
    );

    assign m_tdata = {{(TDATA_W - TOK_BITS){1'b0}},
                      head.column, head.line, head.length, head.offset, head.kind};
    assign m_tlast = head.last;

endmodule
`default_nettype wire

### rtl/kwl_core.sv
// Lexer core: input register, position counters, word tracking and keyword
// prefix matching. Produces up to two tokens per byte. Uses kwl_pkg.
`default_nettype none
module kwl_core
    import kwl_pkg::*;
#(
    parameter int COUNTER_WIDTH = CNT_WIDTH_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [CHAR_W-1:0] in_char,
    input  wire logic              room,
    output logic [1:0]             push_n,
    output tok_t                   tok0,
    output tok_t                   tok1
);

    localparam int CW = COUNTER_WIDTH;
    localparam logic [3:0] KM_NONE   = 4'd0;
    localparam logic [3:0] KM_I      = 4'd1;
    localparam logic [3:0] KM_IF     = 4'd2;
    localparam logic [3:0] KM_E      = 4'd3;
    localparam logic [3:0] KM_EL     = 4'd4;
    localparam logic [3:0] KM_ELS    = 4'd5;
    localparam logic [3:0] KM_ELSE   = 4'd6;
    localparam logic [3:0] KM_ELSEI  = 4'd7;
    localparam logic [3:0] KM_ELSEIF = 4'd8;

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
        return (&v) ? v : v + CW'(1);
    endfunction

    function automatic logic [FIELD_W-1:0] to_field(input logic [CW-1:0] v);
        logic [FIELD_W+CW-1:0] w;
        w = {{FIELD_W{1'b0}}, v};
        return w[FIELD_W-1:0];
    endfunction

    function automatic logic in_range(input logic [CHAR_W-1:0] c,
                                      input logic [CHAR_W-1:0] lo,
                                      input logic [CHAR_W-1:0] hi);
        return (c >= lo) && (c <= hi);
    endfunction

    logic              valid_reg;
    logic [CHAR_W-1:0] char_reg;
    logic [CW-1:0]     offset_reg, offset_next;
    logic [CW-1:0]     line_reg, line_next;
    logic [CW-1:0]     col_reg, col_next;
    logic              active_reg, active_next;
    logic [CW-1:0]     wofs_reg, wofs_next;
    logic [CW-1:0]     wline_reg, wline_next;
    logic [CW-1:0]     wcol_reg, wcol_next;
    logic [CW-1:0]     wlen_reg, wlen_next;
    logic [3:0]        km_reg, km_next;

    logic       advance;
    logic       is_letter, is_word, is_ws, has_word, has_single;
    logic [3:0] km_step;
    tok_t       wtok, stok;

    assign advance  = valid_reg && room;
    assign in_ready = !valid_reg || room;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            char_reg <= in_char;
        end
    end

    always_comb begin
        is_letter = (in_range(char_reg, CH_LOW_A, CH_LOW_Z))
                 || (in_range(char_reg, CH_UP_A, CH_UP_Z)) || (char_reg == CH_UNDER);
        is_word   = is_letter || in_range(char_reg, CH_DIG_0, CH_DIG_9);
        is_ws     = (char_reg == CH_SPACE) || (char_reg == CH_NL) || (char_reg == CH_TAB);
        unique case (km_reg)
            KM_I:     km_step = (char_reg == CH_F) ? KM_IF     : KM_NONE;
            KM_E:     km_step = (char_reg == CH_L) ? KM_EL     : KM_NONE;
            KM_EL:    km_step = (char_reg == CH_S) ? KM_ELS    : KM_NONE;
            KM_ELS:   km_step = (char_reg == CH_E) ? KM_ELSE   : KM_NONE;
            KM_ELSE:  km_step = (char_reg == CH_I) ? KM_ELSEI  : KM_NONE;
            KM_ELSEI: km_step = (char_reg == CH_F) ? KM_ELSEIF : KM_NONE;
            default:  km_step = KM_NONE;
        endcase
    end

    always_comb begin
        wtok        = '0;
        wtok.offset = to_field(wofs_reg);
        wtok.length = to_field(wlen_reg);
        wtok.line   = to_field(wline_reg);
        wtok.column = to_field(wcol_reg);
        priority if (km_reg == KM_IF && (is_ws || char_reg == CH_LPAREN)) begin
            wtok.kind = TOK_IF;
        end else if (km_reg == KM_ELSE && (is_ws || char_reg == CH_LBRACE)) begin
            wtok.kind = TOK_ELSE;
        end else if (km_reg == KM_ELSEIF && (is_ws || char_reg == CH_LBRACE)) begin
            wtok.kind = TOK_ELSEIF;
        end else begin
            wtok.kind = TOK_IDENT;
        end

        stok        = '0;
        stok.kind   = single_kind(char_reg);
        stok.offset = to_field(offset_reg);
        stok.length = to_field(CW'(1));
        stok.line   = to_field(line_reg);
        stok.column = to_field(col_reg);
        stok.last   = 1'b1;
    end

    always_comb begin
        offset_next = offset_reg;
        line_next   = line_reg;
        col_next    = col_reg;
        active_next = active_reg;
        wofs_next   = wofs_reg;
        wline_next  = wline_reg;
        wcol_next   = wcol_reg;
        wlen_next   = wlen_reg;
        km_next     = km_reg;
        has_word    = 1'b0;
        has_single  = 1'b0;

        if (active_reg && is_word) begin
            wlen_next   = sat_inc(wlen_reg);
            km_next     = km_step;
            offset_next = sat_inc(offset_reg);
            col_next    = sat_inc(col_reg);
        end else begin
            has_word    = active_reg;
            active_next = 1'b0;
            km_next     = KM_NONE;
            offset_next = sat_inc(offset_reg);
            if (char_reg == CH_NL) begin
                col_next  = '0;
                line_next = sat_inc(line_reg);
            end else if (is_ws) begin
                col_next = sat_inc(col_reg);
            end else if (is_letter) begin
                active_next = 1'b1;
                wofs_next   = offset_reg;
                wline_next  = line_reg;
                wcol_next   = col_reg;
                wlen_next   = CW'(1);
                km_next     = (char_reg == CH_I) ? KM_I :
                              (char_reg == CH_E) ? KM_E : KM_NONE;
                col_next    = sat_inc(col_reg);
            end else begin
                has_single = 1'b1;
                col_next   = sat_inc(col_reg);
            end
        end
    end

    always_comb begin
        tok1 = stok;
        if (has_word) begin
            tok0      = wtok;
            tok0.last = !has_single;
        end else begin
            tok0 = stok;
        end
        push_n = advance ? ({1'b0, has_word} + {1'b0, has_single}) : 2'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= '0;
            line_reg   <= '0;
            col_reg    <= '0;
            active_reg <= 1'b0;
            wofs_reg   <= '0;
            wline_reg  <= '0;
            wcol_reg   <= '0;
            wlen_reg   <= '0;
            km_reg     <= KM_NONE;
        end else if (advance) begin
            offset_reg <= offset_next;
            line_reg   <= line_next;
            col_reg    <= col_next;
            active_reg <= active_next;
            wofs_reg   <= wofs_next;
            wline_reg  <= wline_next;
            wcol_reg   <= wcol_next;
            wlen_reg   <= wlen_next;
            km_reg     <= km_next;
        end
    end

    // A keyword prefix is only tracked while a word is open.
    a_km_needs_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (km_reg != KM_NONE) |-> active_reg)
        else $error("keyword prefix without open word");

    // Every transfer pair carries the word token first and a closing symbol second.
    a_two_tokens: assert property (@(posedge aclk) disable iff (!aresetn)
        (push_n == 2'd2) |-> (!tok0.last && tok1.last && active_reg))
        else $error("bad two-token group");

    // The offset counter moves only when a registered byte advances; it steps by at most one.
    a_offset_step: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(offset_reg))
        else $error("offset changed without a byte");

endmodule
`default_nettype wire

### rtl/kwl_tok_fifo.sv
// Four-entry token queue that takes zero, one or two tokens per cycle and
// releases one per output transfer. Uses kwl_pkg.
`default_nettype none
module kwl_tok_fifo
    import kwl_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic [1:0] push_n,
    input  tok_t            tok0,
    input  tok_t            tok1,
    output logic            room,
    output logic            out_valid,
    input  wire logic       out_ready,
    output tok_t            out_tok
);

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    tok_t            mem_reg [DEPTH];
    logic [AW-1:0]   wptr_reg, rptr_reg;
    logic [AW:0]     count_reg, count_next;
    logic            pop;

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && out_ready;
    assign room      = (count_reg <= (AW+1)'(DEPTH - 2));
    assign out_tok   = mem_reg[rptr_reg];
    assign count_next = count_reg + {{(AW-1){1'b0}}, push_n} - {{AW{1'b0}}, pop};

    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            mem_reg[wptr_reg] <= tok0;
        end
        if (push_n == 2'd2) begin
            mem_reg[wptr_reg + AW'(1)] <= tok1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_reg + AW'(push_n);
            rptr_reg  <= rptr_reg + AW'(pop);
            count_reg <= count_next;
        end
    end

    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (AW+1)'(DEPTH))
        else $error("token queue overflow");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (push_n != 2'd0) |-> room)
        else $error("push without room");

    a_count_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (push_n == 2'd0 && !pop) |=> $stable(count_reg))
        else $error("queue level moved while idle");

endmodule
`default_nettype wire

### tb/tb_keyword_token_lexer_top.sv
// Self-checking testbench for keyword_token_lexer_top: a directed table, random source text and
// a back-to-back burst are streamed in; tokens are checked against given rows or an in-bench lexer.
// Depends on kwl_pkg and the keyword_token_lexer_top RTL.
`default_nettype none
module tb_keyword_token_lexer_top;
    import kwl_pkg::*;

    localparam int unsigned LIMIT_CYCLES = 2_000_000;
    localparam int          RANDOM_ITEMS = 1780;
    localparam int          BURST_PAIRS  = 16;
    localparam int          DIR_N        = 34;
    localparam logic [CHAR_W-1:0] CH_TOP = 8'hFF;

    typedef enum logic [3:0] {
        KW_NONE, KW_I, KW_IF, KW_E, KW_EL, KW_ELS, KW_ELSE, KW_ELSEI, KW_ELSEIF
    } kw_t;

    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              typed;
        tok_t              want;
    } row_t;

    logic               aclk;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [CHAR_W-1:0]  s_tdata  = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic               m_tlast;

    int unsigned cyc        = 0;
    int          errors     = 0;
    int          stall_left = 0;
    int          rx_gap;
    bit          bulk       = 1'b0;

    tok_t              tokens_due[$];
    logic [CHAR_W-1:0] text_q[$];

    logic [FIELD_W-1:0] at_offset   = '0;
    logic [FIELD_W-1:0] at_line     = '0;
    logic [FIELD_W-1:0] at_column   = '0;
    logic               word_open   = 1'b0;
    logic [FIELD_W-1:0] word_offset = '0;
    logic [FIELD_W-1:0] word_line   = '0;
    logic [FIELD_W-1:0] word_column = '0;
    logic [FIELD_W-1:0] word_len    = '0;
    kw_t                kw_state    = KW_NONE;

    row_t dir_rows [DIR_N] = '{
        '{CH_NUL, 1'b1, '{kind: TOK_EOF, offset: 16'd0, length: 16'd1,
                          line: 16'd0, column: 16'd0, last: 1'b1}},
        '{CH_TOP, 1'b1, '{kind: TOK_UNKNOWN, offset: 16'd1, length: 16'd1,
                          line: 16'd0, column: 16'd1, last: 1'b1}},
        '{CH_LPAREN, 1'b1, '{kind: TOK_LPAREN, offset: 16'd2, length: 16'd1,
                             line: 16'd0, column: 16'd2, last: 1'b1}},
        '{CH_DIG_9, 1'b1, '{kind: TOK_UNKNOWN, offset: 16'd3, length: 16'd1,
                            line: 16'd0, column: 16'd3, last: 1'b1}},
        '{CH_I, 1'b0, '0}, '{CH_F, 1'b0, '0}, '{CH_LPAREN, 1'b0, '0},
        '{CH_E, 1'b0, '0}, '{CH_L, 1'b0, '0}, '{CH_S, 1'b0, '0}, '{CH_E, 1'b0, '0},
        '{CH_LBRACE, 1'b0, '0},
        '{CH_NL, 1'b0, '0},
        '{CH_E, 1'b0, '0}, '{CH_L, 1'b0, '0}, '{CH_S, 1'b0, '0}, '{CH_E, 1'b0, '0},
        '{CH_I, 1'b0, '0}, '{CH_F, 1'b0, '0}, '{CH_TAB, 1'b0, '0},
        '{CH_I, 1'b0, '0}, '{CH_F, 1'b0, '0}, '{CH_NUL, 1'b0, '0},
        '{CH_UNDER, 1'b0, '0}, '{CH_DIG_9, 1'b0, '0}, '{CH_RPAREN, 1'b0, '0},
        '{CH_RBRACE, 1'b0, '0}, '{CH_SEMI, 1'b0, '0}, '{CH_ASSIGN, 1'b0, '0},
        '{CH_PLUS, 1'b0, '0}, '{CH_MINUS, 1'b0, '0}, '{CH_SLASH, 1'b0, '0},
        '{CH_STAR, 1'b0, '0}, '{CH_SPACE, 1'b0, '0}
    };

    logic [CHAR_W-1:0] sym_set [11] = '{
        CH_NUL, CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE, CH_SEMI,
        CH_ASSIGN, CH_PLUS, CH_MINUS, CH_SLASH, CH_STAR
    };
    string kw_text [3] = '{"if", "else", "elseif"};

    keyword_token_lexer_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (cyc == LIMIT_CYCLES) begin
            $display("tb_keyword_token_lexer_top NOT OK");
            $finish;
        end
    end

    function automatic logic [FIELD_W-1:0] sat_inc(input logic [FIELD_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic is_letter(input logic [CHAR_W-1:0] c);
        return (c >= CH_LOW_A && c <= CH_LOW_Z) || (c >= CH_UP_A && c <= CH_UP_Z)
            || c == CH_UNDER;
    endfunction

    function automatic logic is_word_char(input logic [CHAR_W-1:0] c);
        return is_letter(c) || (c >= CH_DIG_0 && c <= CH_DIG_9);
    endfunction

    function automatic logic [KIND_W-1:0] symbol_kind(input logic [CHAR_W-1:0] c);
        case (c)
            CH_NUL:    return TOK_EOF;
            CH_LPAREN: return TOK_LPAREN;
            CH_RPAREN: return TOK_RPAREN;
            CH_LBRACE: return TOK_LBRACE;
            CH_RBRACE: return TOK_RBRACE;
            CH_SEMI:   return TOK_SEMI;
            CH_ASSIGN: return TOK_ASSIGN;
            CH_PLUS:   return TOK_PLUS;
            CH_MINUS:  return TOK_MINUS;
            CH_SLASH:  return TOK_SLASH;
            CH_STAR:   return TOK_STAR;
            default:   return TOK_UNKNOWN;
        endcase
    endfunction

    function automatic kw_t kw_next(input kw_t m, input logic [CHAR_W-1:0] c);
        case (m)
            KW_I:     return (c == CH_F) ? KW_IF : KW_NONE;
            KW_E:     return (c == CH_L) ? KW_EL : KW_NONE;
            KW_EL:    return (c == CH_S) ? KW_ELS : KW_NONE;
            KW_ELS:   return (c == CH_E) ? KW_ELSE : KW_NONE;
            KW_ELSE:  return (c == CH_I) ? KW_ELSEI : KW_NONE;
            KW_ELSEI: return (c == CH_F) ? KW_ELSEIF : KW_NONE;
            default:  return KW_NONE;
        endcase
    endfunction

    // Advances the lexer state by one byte and returns the tokens that byte closes.
    task automatic lex_step(input logic [CHAR_W-1:0] c, output tok_t outs [2], output int n);
        logic              ws;
        logic [KIND_W-1:0] k;
        n = 0;
        outs[0] = '0;
        outs[1] = '0;
        ws = (c == CH_SPACE) || (c == CH_NL) || (c == CH_TAB);
        if (word_open && is_word_char(c)) begin
            word_len  = sat_inc(word_len);
            kw_state  = kw_next(kw_state, c);
            at_offset = sat_inc(at_offset);
            at_column = sat_inc(at_column);
        end else begin
            if (word_open) begin
                k = TOK_IDENT;
                if (kw_state == KW_IF && (ws || c == CH_LPAREN))
                    k = TOK_IF;
                else if (kw_state == KW_ELSE && (ws || c == CH_LBRACE))
                    k = TOK_ELSE;
                else if (kw_state == KW_ELSEIF && (ws || c == CH_LBRACE))
                    k = TOK_ELSEIF;
                outs[n] = '{kind: k, offset: word_offset, length: word_len,
                            line: word_line, column: word_column, last: 1'b0};
                n++;
                word_open = 1'b0;
                kw_state  = KW_NONE;
            end
            if (c == CH_NL) begin
                at_column = '0;
                at_line   = sat_inc(at_line);
                at_offset = sat_inc(at_offset);
            end else if (ws) begin
                at_column = sat_inc(at_column);
                at_offset = sat_inc(at_offset);
            end else if (is_letter(c)) begin
                word_open   = 1'b1;
                word_offset = at_offset;
                word_line   = at_line;
                word_column = at_column;
                word_len    = 16'd1;
                kw_state    = (c == CH_I) ? KW_I : (c == CH_E) ? KW_E : KW_NONE;
                at_offset   = sat_inc(at_offset);
                at_column   = sat_inc(at_column);
            end else begin
                outs[n] = '{kind: symbol_kind(c), offset: at_offset, length: 16'd1,
                            line: at_line, column: at_column, last: 1'b0};
                n++;
                at_offset = sat_inc(at_offset);
                at_column = sat_inc(at_column);
            end
            if (n > 0)
                outs[n-1].last = 1'b1;
        end
    endtask

    // Idle stretches come in windows: one window in four has no gaps at all.
    function automatic int pick_gap(input bit quiet);
        int r;
        if (quiet || cyc[9:8] == 2'b00)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string msg);
        if (errors < 40)
            $display("cycle %0d: %s", cyc, msg);
        errors++;
    endtask

    task automatic check_token();
        tok_t want;
        if (tokens_due.size() == 0) begin
            report_mismatch($sformatf("token kind %0d with none expected", m_tdata[3:0]));
            return;
        end
        want = tokens_due.pop_front();
        if (m_tdata[3:0] != want.kind)
            report_mismatch($sformatf("kind %0d, want %0d", m_tdata[3:0], want.kind));
        if (m_tdata[19:4] != want.offset)
            report_mismatch($sformatf("offset %0d, want %0d", m_tdata[19:4], want.offset));
        if (m_tdata[35:20] != want.length)
            report_mismatch($sformatf("length %0d, want %0d", m_tdata[35:20], want.length));
        if (m_tdata[51:36] != want.line)
            report_mismatch($sformatf("line %0d, want %0d", m_tdata[51:36], want.line));
        if (m_tdata[67:52] != want.column)
            report_mismatch($sformatf("column %0d, want %0d", m_tdata[67:52], want.column));
        if (m_tlast != want.last)
            report_mismatch($sformatf("tlast %0b, want %0b", m_tlast, want.last));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else begin
            if (m_tvalid && m_tready)
                check_token();
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_tready   <= 1'b0;
            end else begin
                rx_gap = pick_gap(1'b0);
                if (rx_gap == 0) begin
                    m_tready <= 1'b1;
                end else begin
                    m_tready   <= 1'b0;
                    stall_left <= rx_gap - 1;
                end
            end
        end
    end

    // Called at a rising edge; returns at the edge where the byte is taken.
    task automatic send_byte(input logic [CHAR_W-1:0] c, input logic typed, input tok_t given);
        tok_t outs [2];
        int   n;
        int   gap;
        gap = pick_gap(bulk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        do @(posedge aclk); while (!s_tready);
        lex_step(c, outs, n);
        if (typed) begin
            tokens_due.push_back(given);
        end else begin
            for (int i = 0; i < n; i++)
                tokens_due.push_back(outs[i]);
        end
    endtask

    task automatic drain_tokens();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (tokens_due.size() != 0);
    endtask

    function automatic logic [CHAR_W-1:0] any_letter();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26)
            return CHAR_W'(CH_LOW_A + r);
        if (r < 52)
            return CHAR_W'(CH_UP_A + (r - 26));
        return CH_UNDER;
    endfunction

    function automatic logic [CHAR_W-1:0] any_word_char();
        int r;
        r = $urandom_range(0, 14);
        return (r < 10) ? CHAR_W'(CH_DIG_0 + r) : any_letter();
    endfunction

    // Mostly well-formed source text: keywords with good or bad delimiters, words that share
    // a keyword prefix, symbols and whitespace, with some raw byte noise.
    task automatic append_phrase();
        int    r;
        int    len;
        int    pick;
        string kw;
        r = $urandom_range(0, 99);
        if (r < 30) begin
            pick = $urandom_range(0, 2);
            kw = kw_text[pick];
            for (int i = 0; i < kw.len(); i++)
                text_q.push_back(kw[i]);
            if ($urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 3))
                    0: text_q.push_back(CH_SPACE);
                    1: text_q.push_back(CH_NL);
                    2: text_q.push_back(CH_TAB);
                    default: text_q.push_back(pick == 0 ? CH_LPAREN : CH_LBRACE);
                endcase
            end else begin
                case ($urandom_range(0, 3))
                    0: text_q.push_back(sym_set[$urandom_range(0, 10)]);
                    1: text_q.push_back(any_word_char());
                    2: text_q.push_back(pick == 0 ? CH_LBRACE : CH_LPAREN);
                    default: text_q.push_back(CHAR_W'($urandom_range(0, 255)));
                endcase
            end
        end else if (r < 55) begin
            if ($urandom_range(0, 3) == 0) begin
                kw = kw_text[$urandom_range(0, 2)];
                len = $urandom_range(1, kw.len());
                for (int i = 0; i < len; i++)
                    text_q.push_back(kw[i]);
            end else begin
                text_q.push_back(any_letter());
            end
            len = $urandom_range(0, 9);
            for (int i = 0; i < len; i++)
                text_q.push_back(any_word_char());
        end else if (r < 75) begin
            text_q.push_back(sym_set[$urandom_range(0, 10)]);
        end else if (r < 90) begin
            case ($urandom_range(0, 2))
                0: text_q.push_back(CH_SPACE);
                1: text_q.push_back(CH_NL);
                default: text_q.push_back(CH_TAB);
            endcase
        end else begin
            text_q.push_back(CHAR_W'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        int sent;
        bit paused;
        sent   = 0;
        paused = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIR_N; i++)
            send_byte(dir_rows[i].ch, dir_rows[i].typed, dir_rows[i].want);
        drain_tokens();

        while (sent < RANDOM_ITEMS) begin
            append_phrase();
            while (text_q.size() != 0) begin
                send_byte(text_q.pop_front(), 1'b0, '0);
                sent++;
            end
            if (!paused && sent >= RANDOM_ITEMS / 2) begin
                paused = 1'b1;
                drain_tokens();
            end
        end
        drain_tokens();

        // Word and symbol pairs with no input gaps give two tokens on every other byte.
        bulk = 1'b1;
        for (int i = 0; i < BURST_PAIRS; i++) begin
            send_byte(any_letter(), 1'b0, '0);
            send_byte(sym_set[i % 11], 1'b0, '0);
        end
        bulk = 1'b0;
        send_byte(CH_LPAREN, 1'b0, '0);
        send_byte(CH_E, 1'b0, '0);
        send_byte(CH_NUL, 1'b0, '0);
        send_byte(CH_NL, 1'b0, '0);
        send_byte(CH_STAR, 1'b0, '0);
        drain_tokens();

        repeat (8) @(posedge aclk);
        if (errors == 0)
            $display("tb_keyword_token_lexer_top OK");
        else
            $display("tb_keyword_token_lexer_top NOT OK");
        $finish;
    end

endmodule
`default_nettype wire
